>>> src/asc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and helpers of the sponge cipher core.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int WORD_W    = 64;
  localparam int NUM_WORDS = 5;
  localparam int COUNT_W   = 5;
  localparam int POS_W     = 4;
  localparam int RND_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] BLOCK_BYTES = 5'd16;

  localparam logic [WORD_W-1:0] IV_128A = 64'h80800c0800000000;
  localparam logic [7:0]        RC_BASE = 8'hf0;
  localparam logic [7:0]        RC_STEP = 8'h0f;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] sponge_t;

  typedef struct packed {
    logic             take_in;
    logic             load_init;
    logic             absorb;
    logic             subst;
    logic             pad;
    logic [POS_W-1:0] pad_pos;
    logic             domain;
    logic             key_mid;
    logic             key_tail;
    logic             round;
    logic [RND_W-1:0] rnd;
    logic             cap_text;
    logic             cap_tag;
  } cmd_t;

  // Byte count clipped to one block
  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] n);
    return (n > BLOCK_BYTES) ? BLOCK_BYTES : n;
  endfunction

  function automatic logic [7:0] round_const(input logic [RND_W-1:0] r);
    return RC_BASE - RC_STEP * {4'd0, r};
  endfunction

endpackage

>>> src/aead_sponge_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aead_sponge_cipher_core
// Ascon-128a authenticated cipher core: init, associated data, encrypt,
// decrypt and finalize on a 320-bit sponge state.
// ----------------------------------------------------------------------------
// One item is worked on at a time; a single permutation round unit runs one
// round per cycle and sets the timing. A full associated-data or text block
// is decoded, absorbed and run through eight rounds; a short last block is
// absorbed and padded, with eight rounds after the pad when it is associated
// data. A full last block adds the empty padded block, and the first text
// block after open associated data first closes it. Init loads the state,
// runs the permutation and mixes in the key; finalize first closes the open
// phase as far as needed. Ignored items are dropped after decode. The
// result register lets the next item enter while a text block or tag waits
// to be taken; a new result is held back only while the previous one is
// still there.
module aead_sponge_cipher_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        func,
  input  logic [asc_pkg::WORD_W-1:0]        word_high,
  input  logic [asc_pkg::WORD_W-1:0]        word_low,
  input  logic [asc_pkg::COUNT_W-1:0]       valid_bytes,
  input  logic                              last_block,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [asc_pkg::WORD_W-1:0]        out_high,
  output logic [asc_pkg::WORD_W-1:0]        out_low,
  output logic [asc_pkg::COUNT_W-1:0]       out_bytes,
  output logic                              is_tag,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [asc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asc_pkg::WORD_W-1:0]        cfg_data
);

  asc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  asc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .valid_bytes (valid_bytes),
    .last_block  (last_block),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd)
  );

  asc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .word_high   (word_high),
    .word_low    (word_low),
    .valid_bytes (valid_bytes),
    .out_high    (out_high),
    .out_low     (out_low),
    .out_bytes   (out_bytes),
    .is_tag      (is_tag)
  );

endmodule

>>> src/asc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_datapath
// Sponge state, key registers, input block store, one permutation round per
// cycle and the result register.
// ----------------------------------------------------------------------------
module asc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  asc_pkg::cmd_t                       cmd,
  input  logic                                cfg_we,
  input  logic [asc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [asc_pkg::WORD_W-1:0]          cfg_data,
  input  logic [asc_pkg::WORD_W-1:0]          word_high,
  input  logic [asc_pkg::WORD_W-1:0]          word_low,
  input  logic [asc_pkg::COUNT_W-1:0]         valid_bytes,
  output logic [asc_pkg::WORD_W-1:0]          out_high,
  output logic [asc_pkg::WORD_W-1:0]          out_low,
  output logic [asc_pkg::COUNT_W-1:0]         out_bytes,
  output logic                                is_tag
);

  localparam logic [asc_pkg::CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [asc_pkg::CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  asc_pkg::sponge_t                  s;
  asc_pkg::sponge_t                  s_next;
  logic [asc_pkg::WORD_W-1:0]        key_high;
  logic [asc_pkg::WORD_W-1:0]        key_low;
  logic [asc_pkg::WORD_W-1:0]        w_high;
  logic [asc_pkg::WORD_W-1:0]        w_low;
  logic [2*asc_pkg::WORD_W-1:0]      mask;
  logic [2*asc_pkg::WORD_W-1:0]      mask_in;
  logic [asc_pkg::COUNT_W-1:0]       n_q;
  logic [asc_pkg::COUNT_W-1:0]       n_in;
  logic [asc_pkg::WORD_W-1:0]        d_high;
  logic [asc_pkg::WORD_W-1:0]        d_low;
  logic [2*asc_pkg::WORD_W-1:0]      rate;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic asc_pkg::sponge_t perm_round(input asc_pkg::sponge_t si,
                                                  input logic [7:0] rc);
    asc_pkg::sponge_t so;
    logic [63:0] a0, a1, a2, a3, a4;
    logic [63:0] n0, n1, n2, n3, n4;
    a0 = si[0] ^ si[4];
    a4 = si[4] ^ si[3];
    a2 = si[2] ^ {56'd0, rc} ^ si[1];
    a1 = si[1];
    a3 = si[3];
    n0 = a0 ^ (~a1 & a2);
    n1 = a1 ^ (~a2 & a3);
    n2 = a2 ^ (~a3 & a4);
    n3 = a3 ^ (~a4 & a0);
    n4 = a4 ^ (~a0 & a1);
    n1 = n1 ^ n0;
    n3 = n3 ^ n2;
    n0 = n0 ^ n4;
    n2 = ~n2;
    so[0] = n0 ^ rotr(n0, 19) ^ rotr(n0, 28);
    so[1] = n1 ^ rotr(n1, 61) ^ rotr(n1, 39);
    so[2] = n2 ^ rotr(n2, 1) ^ rotr(n2, 6);
    so[3] = n3 ^ rotr(n3, 10) ^ rotr(n3, 17);
    so[4] = n4 ^ rotr(n4, 7) ^ rotr(n4, 41);
    return so;
  endfunction

  assign n_in = asc_pkg::sat_count(valid_bytes);

  // Byte 0 is the top byte of word_high
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask_in[127-8*i -: 8] = (5'(i) < n_in) ? 8'hff : 8'h00;
    end
  end

  assign d_high = w_high & mask[127:64];
  assign d_low  = w_low & mask[63:0];

  always_comb begin
    s_next = s;
    rate   = {s[0], s[1]};
    if (cmd.load_init) begin
      s_next[0] = asc_pkg::IV_128A;
      s_next[1] = key_high;
      s_next[2] = key_low;
      s_next[3] = w_high;
      s_next[4] = w_low;
    end
    if (cmd.absorb) begin
      s_next[0] = s[0] ^ d_high;
      s_next[1] = s[1] ^ d_low;
    end
    if (cmd.subst) begin
      s_next[0] = (s[0] & ~mask[127:64]) | d_high;
      s_next[1] = (s[1] & ~mask[63:0]) | d_low;
    end
    if (cmd.pad) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) == cmd.pad_pos) begin
          rate[127-8*i] = ~rate[127-8*i];
        end
      end
      s_next[0] = rate[127:64];
      s_next[1] = rate[63:0];
    end
    if (cmd.domain) begin
      s_next[4] = s[4] ^ 64'd1;
    end
    if (cmd.key_mid) begin
      s_next[2] = s[2] ^ key_high;
      s_next[3] = s[3] ^ key_low;
    end
    if (cmd.key_tail) begin
      s_next[3] = s[3] ^ key_high;
      s_next[4] = s[4] ^ key_low;
    end
    if (cmd.round) begin
      s_next = perm_round(s, asc_pkg::round_const(cmd.rnd));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s        <= '0;
      key_high <= '0;
      key_low  <= '0;
    end else begin
      s <= s_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_HIGH: key_high <= cfg_data;
          REG_KEY_LOW:  key_low  <= cfg_data;
          default:      ;
        endcase
      end
    end
  end

  // Payload registers: item store and result
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      w_high <= word_high;
      w_low  <= word_low;
      mask   <= mask_in;
      n_q    <= n_in;
    end
    if (cmd.cap_text) begin
      out_high  <= (s[0] ^ d_high) & mask[127:64];
      out_low   <= (s[1] ^ d_low) & mask[63:0];
      out_bytes <= n_q;
      is_tag    <= 1'b0;
    end else if (cmd.cap_tag) begin
      out_high  <= s[3] ^ key_high;
      out_low   <= s[4] ^ key_low;
      out_bytes <= asc_pkg::BLOCK_BYTES;
      is_tag    <= 1'b1;
    end
  end

endmodule

>>> src/asc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_ctrl
// Sequencer: decodes each item against the sponge phase and steps the
// datapath through loads, pads, key mixes and permutation rounds.
// ----------------------------------------------------------------------------
module asc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  func,
  input  logic [asc_pkg::COUNT_W-1:0] valid_bytes,
  input  logic                        last_block,
  output logic                        out_valid,
  input  logic                        out_ready,
  output asc_pkg::cmd_t               cmd
);

  localparam logic [2:0] FUNC_INIT = 3'd0;
  localparam logic [2:0] FUNC_AD   = 3'd1;
  localparam logic [2:0] FUNC_ENC  = 3'd2;
  localparam logic [2:0] FUNC_DEC  = 3'd3;
  localparam logic [2:0] FUNC_FIN  = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_INIT = 2'd1;
  localparam logic [1:0] PH_AD   = 2'd2;
  localparam logic [1:0] PH_TEXT = 2'd3;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_INIT_LOAD = 4'd2;
  localparam logic [3:0] S_INIT_KEY  = 4'd3;
  localparam logic [3:0] S_AD_ABSORB = 4'd4;
  localparam logic [3:0] S_AD_PAD    = 4'd5;
  localparam logic [3:0] S_DOMAIN    = 4'd6;
  localparam logic [3:0] S_CLOSE_PAD = 4'd7;
  localparam logic [3:0] S_CLOSE_DOM = 4'd8;
  localparam logic [3:0] S_TEXT      = 4'd9;
  localparam logic [3:0] S_TEXT_PAD  = 4'd10;
  localparam logic [3:0] S_FIN_PAD   = 4'd11;
  localparam logic [3:0] S_KEY_MID   = 4'd12;
  localparam logic [3:0] S_TAG       = 4'd13;
  localparam logic [3:0] S_ROUNDS    = 4'd14;

  localparam logic [asc_pkg::RND_W-1:0] P12_FIRST  = 4'd0;
  localparam logic [asc_pkg::RND_W-1:0] P8_FIRST   = 4'd4;
  localparam logic [asc_pkg::RND_W-1:0] LAST_ROUND = 4'd11;

  logic [3:0]                  state, state_next;
  logic [3:0]                  ret, ret_next;
  logic [asc_pkg::RND_W-1:0]   rnd, rnd_next;
  logic [1:0]                  phase, phase_next;
  logic [2:0]                  func_q;
  logic [asc_pkg::COUNT_W-1:0] n_q;
  logic                        last_q;
  logic                        out_valid_next;
  logic                        take_in;
  logic                        out_free;
  logic                        full;

  assign in_ready = (state == S_IDLE);
  assign take_in  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign full     = (n_q == asc_pkg::BLOCK_BYTES);

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    rnd_next       = rnd;
    phase_next     = phase;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.take_in    = take_in;
    cmd.rnd        = rnd;
    // a short last block pads right after its bytes, a full one at byte 0
    cmd.pad_pos    = n_q[asc_pkg::POS_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (take_in) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        unique case (func_q) inside
          FUNC_INIT: state_next = S_INIT_LOAD;
          FUNC_AD: begin
            if (phase == PH_INIT && last_q && n_q == '0) begin
              state_next = S_DOMAIN;
            end else if (phase == PH_INIT || phase == PH_AD) begin
              state_next = S_AD_ABSORB;
            end
          end
          FUNC_ENC, FUNC_DEC: begin
            if (phase == PH_AD) begin
              state_next = S_CLOSE_PAD;
            end else if (phase == PH_INIT) begin
              state_next = S_CLOSE_DOM;
            end else if (phase == PH_TEXT) begin
              state_next = S_TEXT;
            end
          end
          FUNC_FIN: begin
            if (phase == PH_AD) begin
              state_next = S_CLOSE_PAD;
            end else if (phase == PH_INIT) begin
              state_next = S_CLOSE_DOM;
            end else if (phase == PH_TEXT) begin
              state_next = S_FIN_PAD;
            end else begin
              state_next = S_KEY_MID;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_INIT_LOAD: begin
        cmd.load_init = 1'b1;
        rnd_next      = P12_FIRST;
        ret_next      = S_INIT_KEY;
        state_next    = S_ROUNDS;
      end
      S_INIT_KEY: begin
        cmd.key_tail = 1'b1;
        phase_next   = PH_INIT;
        state_next   = S_IDLE;
      end
      S_AD_ABSORB: begin
        cmd.absorb = 1'b1;
        phase_next = PH_AD;
        if (!last_q || full) begin
          rnd_next   = P8_FIRST;
          ret_next   = last_q ? S_AD_PAD : S_IDLE;
          state_next = S_ROUNDS;
        end else begin
          state_next = S_AD_PAD;
        end
      end
      S_AD_PAD: begin
        cmd.pad    = 1'b1;
        rnd_next   = P8_FIRST;
        ret_next   = S_DOMAIN;
        state_next = S_ROUNDS;
      end
      S_DOMAIN: begin
        cmd.domain = 1'b1;
        phase_next = PH_TEXT;
        state_next = S_IDLE;
      end
      S_CLOSE_PAD: begin
        // empty padded block closes the open associated data
        cmd.pad     = 1'b1;
        cmd.pad_pos = '0;
        rnd_next    = P8_FIRST;
        ret_next    = S_CLOSE_DOM;
        state_next  = S_ROUNDS;
      end
      S_CLOSE_DOM: begin
        cmd.domain = 1'b1;
        phase_next = PH_TEXT;
        state_next = (func_q == FUNC_FIN) ? S_FIN_PAD : S_TEXT;
      end
      S_TEXT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.absorb     = (func_q != FUNC_DEC);
          cmd.subst      = (func_q == FUNC_DEC);
          cmd.cap_text   = 1'b1;
          out_valid_next = 1'b1;
          if (!last_q || full) begin
            rnd_next   = P8_FIRST;
            ret_next   = last_q ? S_TEXT_PAD : S_IDLE;
            state_next = S_ROUNDS;
          end else begin
            state_next = S_TEXT_PAD;
          end
        end
      end
      S_TEXT_PAD: begin
        cmd.pad    = 1'b1;
        phase_next = PH_IDLE;
        state_next = S_IDLE;
      end
      S_FIN_PAD: begin
        cmd.pad     = 1'b1;
        cmd.pad_pos = '0;
        state_next  = S_KEY_MID;
      end
      S_KEY_MID: begin
        cmd.key_mid = 1'b1;
        rnd_next    = P12_FIRST;
        ret_next    = S_TAG;
        state_next  = S_ROUNDS;
      end
      S_TAG: begin
        if (out_free) begin
          cmd.key_tail   = 1'b1;
          cmd.cap_tag    = 1'b1;
          out_valid_next = 1'b1;
          phase_next     = PH_IDLE;
          state_next     = S_IDLE;
        end
      end
      S_ROUNDS: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 4'd1;
        if (rnd == LAST_ROUND) begin
          state_next = ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      rnd       <= '0;
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      rnd       <= rnd_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      func_q <= func;
      n_q    <= asc_pkg::sat_count(valid_bytes);
      last_q <= last_block;
    end
  end

endmodule

>>> tb/sv/aead_sponge_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aead_sponge_cipher_checker
// Operation and register codes shared by the bench, and a checker that
// follows the key writes and accepted items of the sponge cipher core. It
// keeps its own copy of the 320-bit sponge and phase, works out each text
// block or tag in advance and compares every result the core hands out.
// ----------------------------------------------------------------------------
package asc_tb_pkg;

  typedef enum logic [2:0] {
    OP_INIT = 3'd0,
    OP_AD   = 3'd1,
    OP_ENC  = 3'd2,
    OP_DEC  = 3'd3,
    OP_FIN  = 3'd4,
    OP_RSV5 = 3'd5,
    OP_RSV6 = 3'd6,
    OP_RSV7 = 3'd7
  } op_e;

  localparam logic [asc_pkg::CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [asc_pkg::CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

endpackage

module aead_sponge_cipher_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [2:0]                    func,
  input  logic [asc_pkg::WORD_W-1:0]    word_high,
  input  logic [asc_pkg::WORD_W-1:0]    word_low,
  input  logic [asc_pkg::COUNT_W-1:0]   valid_bytes,
  input  logic                          last_block,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [asc_pkg::WORD_W-1:0]    out_high,
  input  logic [asc_pkg::WORD_W-1:0]    out_low,
  input  logic [asc_pkg::COUNT_W-1:0]   out_bytes,
  input  logic                          is_tag,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [asc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asc_pkg::WORD_W-1:0]    cfg_data,
  output int                            expected_left,
  output int                            fail_count,
  output int                            text_seen,
  output int                            tag_seen
);

  localparam logic [63:0] INIT_VECTOR = 64'h80800c0800000000;
  localparam logic [63:0] PAD_TOP     = 64'h8000000000000000;
  localparam logic [7:0]  RC_FIRST    = 8'hf0;
  localparam logic [7:0]  RC_STEP     = 8'h0f;
  localparam int          MAX_REPORTS = 10;

  typedef logic [4:0][63:0] state_words_t;

  typedef enum logic [1:0] {PH_IDLE, PH_KEYED, PH_AD, PH_TEXT} sponge_phase_e;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    logic        tag;
  } cipher_out_t;

  state_words_t  st;
  sponge_phase_e ph;
  logic [63:0]   key_hi;
  logic [63:0]   key_lo;
  cipher_out_t   pending_out[$];
  int            mismatches = 0;
  int            texts = 0;
  int            tags = 0;

  initial begin
    expected_left = 0;
    fail_count    = 0;
    text_seen     = 0;
    tag_seen      = 0;
  end

  function automatic logic [63:0] ror64(logic [63:0] v, int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic state_words_t sponge_round(state_words_t s, logic [63:0] rc);
    logic [63:0] a0, a1, a2, a3, a4, n0, n1, n2, n3, n4;
    s[2] = s[2] ^ rc;
    a0 = s[0] ^ s[4];
    a4 = s[4] ^ s[3];
    a2 = s[2] ^ s[1];
    a1 = s[1];
    a3 = s[3];
    n0 = a0 ^ (~a1 & a2);
    n1 = a1 ^ (~a2 & a3);
    n2 = a2 ^ (~a3 & a4);
    n3 = a3 ^ (~a4 & a0);
    n4 = a4 ^ (~a0 & a1);
    n1 = n1 ^ n0;
    n3 = n3 ^ n2;
    n0 = n0 ^ n4;
    n2 = ~n2;
    s[0] = n0 ^ ror64(n0, 19) ^ ror64(n0, 28);
    s[1] = n1 ^ ror64(n1, 61) ^ ror64(n1, 39);
    s[2] = n2 ^ ror64(n2, 1) ^ ror64(n2, 6);
    s[3] = n3 ^ ror64(n3, 10) ^ ror64(n3, 17);
    s[4] = n4 ^ ror64(n4, 7) ^ ror64(n4, 41);
    return s;
  endfunction

  // Rounds first..11: first 0 is the twelve-round pass, first 4 the eight-round one
  function automatic state_words_t permute(state_words_t s, int unsigned first);
    int unsigned r;
    logic [63:0] rc;
    for (r = first; r < 12; r++) begin
      rc = 64'(RC_FIRST) - 64'(RC_STEP) * 64'(r);
      s = sponge_round(s, rc);
    end
    return s;
  endfunction

  function automatic logic [63:0] byte_mask(int unsigned k);
    if (k == 0) return '0;
    if (k >= 8) return '1;
    return ~64'd0 << (64 - 8 * k);
  endfunction

  function automatic void add_pad(int unsigned pos);
    if (pos < 8) st[0] = st[0] ^ (PAD_TOP >> (8 * pos));
    else if (pos < 16) st[1] = st[1] ^ (PAD_TOP >> (8 * (pos - 8)));
  endfunction

  function automatic void close_assoc();
    if (ph == PH_AD) begin
      add_pad(0);
      st = permute(st, 4);
    end
    if (ph == PH_KEYED || ph == PH_AD) begin
      st[4] = st[4] ^ 64'd1;
      ph = PH_TEXT;
    end
  endfunction

  // Advance the sponge by one item; returns 1 when the item yields a result
  function automatic bit cipher_step(input logic [2:0] f, input logic [63:0] wh,
                                     input logic [63:0] wl, input logic [4:0] vb,
                                     input logic lb, output cipher_out_t res);
    logic [4:0]  n;
    logic [63:0] mh, ml, dh, dl;
    res = '0;
    n  = (vb > 5'd16) ? 5'd16 : vb;
    mh = byte_mask(n);
    ml = byte_mask((n > 5'd8) ? n - 5'd8 : 0);
    dh = wh & mh;
    dl = wl & ml;
    case (f) inside
      asc_tb_pkg::OP_INIT: begin
        st[0] = INIT_VECTOR;
        st[1] = key_hi;
        st[2] = key_lo;
        st[3] = wh;
        st[4] = wl;
        st = permute(st, 0);
        st[3] = st[3] ^ key_hi;
        st[4] = st[4] ^ key_lo;
        ph = PH_KEYED;
        return 1'b0;
      end
      asc_tb_pkg::OP_AD: begin
        if (ph == PH_IDLE || ph == PH_TEXT) return 1'b0;
        if (ph == PH_KEYED && lb && n == 0) begin
          st[4] = st[4] ^ 64'd1;
          ph = PH_TEXT;
          return 1'b0;
        end
        st[0] = st[0] ^ dh;
        st[1] = st[1] ^ dl;
        ph = PH_AD;
        if (!lb || n == 5'd16) st = permute(st, 4);
        if (lb) begin
          add_pad((n == 5'd16) ? 0 : n);
          st = permute(st, 4);
          st[4] = st[4] ^ 64'd1;
          ph = PH_TEXT;
        end
        return 1'b0;
      end
      asc_tb_pkg::OP_ENC, asc_tb_pkg::OP_DEC: begin
        if (ph == PH_IDLE) return 1'b0;
        close_assoc();
        if (f == asc_tb_pkg::OP_ENC) begin
          st[0] = st[0] ^ dh;
          st[1] = st[1] ^ dl;
          res.hi = st[0] & mh;
          res.lo = st[1] & ml;
        end else begin
          res.hi = (st[0] ^ dh) & mh;
          res.lo = (st[1] ^ dl) & ml;
          st[0] = (st[0] & ~mh) | dh;
          st[1] = (st[1] & ~ml) | dl;
        end
        if (!lb || n == 5'd16) st = permute(st, 4);
        if (lb) begin
          add_pad((n == 5'd16) ? 0 : n);
          ph = PH_IDLE;
        end
        res.nbytes = n;
        res.tag    = 1'b0;
        return 1'b1;
      end
      asc_tb_pkg::OP_FIN: begin
        if (ph == PH_KEYED || ph == PH_AD) close_assoc();
        if (ph == PH_TEXT) add_pad(0);
        st[2] = st[2] ^ key_hi;
        st[3] = st[3] ^ key_lo;
        st = permute(st, 0);
        st[3] = st[3] ^ key_hi;
        st[4] = st[4] ^ key_lo;
        ph = PH_IDLE;
        res.hi     = st[3];
        res.lo     = st[4];
        res.nbytes = 5'd16;
        res.tag    = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : track
    cipher_out_t want;
    cipher_out_t got;
    bit          has_out;
    if (rst) begin
      key_hi = '0;
      key_lo = '0;
      st     = '0;
      ph     = PH_IDLE;
      pending_out.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == asc_tb_pkg::REG_KEY_HIGH) key_hi = cfg_data;
        else if (cfg_index == asc_tb_pkg::REG_KEY_LOW) key_lo = cfg_data;
      end
      if (in_valid && in_ready) begin
        has_out = cipher_step(func, word_high, word_low, valid_bytes, last_block, want);
        if (has_out) pending_out.insert(pending_out.size(), want);
      end
      if (out_valid && out_ready) begin
        got.hi     = out_high;
        got.lo     = out_low;
        got.nbytes = out_bytes;
        got.tag    = is_tag;
        if (pending_out.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%t: unexpected result high=%h low=%h bytes=%0d tag=%b",
                     $realtime, got.hi, got.lo, got.nbytes, got.tag);
        end else begin
          want = pending_out.pop_front();
          if (want.tag) tags++;
          else texts++;
          if (got.hi !== want.hi || got.lo !== want.lo || got.nbytes !== want.nbytes ||
              got.tag !== want.tag) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%t: result differs: high=%h low=%h bytes=%0d tag=%b",
                       $realtime, got.hi, got.lo, got.nbytes, got.tag);
              $display("    expected:        high=%h low=%h bytes=%0d tag=%b",
                       want.hi, want.lo, want.nbytes, want.tag);
            end
          end
        end
      end
    end
    expected_left <= pending_out.size();
    fail_count    <= mismatches;
    text_seen     <= texts;
    tag_seen      <= tags;
  end

endmodule

>>> tb/sv/tb_aead_sponge_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aead_sponge_cipher_core
// Drives the sponge cipher core with a short directed run over the corner
// cases, then randomised init / AD / text / finalize sequences under four
// more keys and several idle and stall mixes; the checker judges results.
// ----------------------------------------------------------------------------
module tb_aead_sponge_cipher_core;

  localparam int          DRAIN_CYCLES   = 40;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PHASE_ITEMS    = 330;
  localparam logic [63:0] ONES64         = '1;
  localparam logic [63:0] ZERO64         = '0;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [2:0]                    func = '0;
  logic [asc_pkg::WORD_W-1:0]    word_high = '0;
  logic [asc_pkg::WORD_W-1:0]    word_low = '0;
  logic [asc_pkg::COUNT_W-1:0]   valid_bytes = '0;
  logic                          last_block = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [asc_pkg::WORD_W-1:0]    out_high;
  logic [asc_pkg::WORD_W-1:0]    out_low;
  logic [asc_pkg::COUNT_W-1:0]   out_bytes;
  logic                          is_tag;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [asc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [asc_pkg::WORD_W-1:0]    cfg_data = '0;

  int expected_left;
  int fail_count;
  int text_seen;
  int tag_seen;

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  aead_sponge_cipher_core dut (.*);

  aead_sponge_cipher_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly full blocks, now and then any count the port can carry
  function automatic logic [4:0] body_count();
    return ($urandom_range(4) != 0) ? 5'd16 : 5'($urandom_range(31));
  endfunction

  function automatic logic [4:0] tail_count();
    return ($urandom_range(9) != 0) ? 5'($urandom_range(16)) : 5'($urandom_range(17, 31));
  endfunction

  task automatic send_item(asc_tb_pkg::op_e op, logic [63:0] wh, logic [63:0] wl,
                           logic [4:0] nb, logic lb, bit counts);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    func        <= op;
    word_high   <= wh;
    word_low    <= wl;
    valid_bytes <= nb;
    last_block  <= lb;
    do @(posedge clk); while (!in_ready);
    if (counts) items_sent++;
  endtask

  // Hold the key writes back to back so valid stays high between them
  task automatic write_key(logic [63:0] kh, logic [63:0] kl);
    cfg_valid <= 1'b1;
    cfg_index <= asc_tb_pkg::REG_KEY_HIGH;
    cfg_data  <= kh;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= asc_tb_pkg::REG_KEY_LOW;
    cfg_data  <= kl;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic hold_off();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  // Drain all results, then give items with no result time to finish
  task automatic settle();
    hold_off();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic directed_items();
    send_item(asc_tb_pkg::OP_FIN, ZERO64, ZERO64, 5'd0, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_AD, ONES64, ONES64, 5'd16, 1'b0, 1'b0);
    send_item(asc_tb_pkg::OP_ENC, ONES64, ONES64, 5'd16, 1'b1, 1'b0);
    send_item(asc_tb_pkg::OP_INIT, ZERO64, ZERO64, 5'd0, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_FIN, ONES64, ONES64, 5'd31, 1'b1, 1'b1);
    send_item(asc_tb_pkg::OP_INIT, ONES64, ONES64, 5'd31, 1'b1, 1'b1);
    send_item(asc_tb_pkg::OP_AD, ONES64, ONES64, 5'd0, 1'b1, 1'b1);
    send_item(asc_tb_pkg::OP_AD, rand64(), rand64(), 5'd16, 1'b0, 1'b0);
    send_item(asc_tb_pkg::OP_ENC, ONES64, ONES64, 5'd16, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_ENC, ONES64, ONES64, 5'd16, 1'b1, 1'b1);
    send_item(asc_tb_pkg::OP_FIN, ZERO64, ZERO64, 5'd16, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_INIT, rand64(), rand64(), 5'd16, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_AD, rand64(), rand64(), 5'd16, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_AD, rand64(), rand64(), 5'd5, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_AD, rand64(), rand64(), 5'd16, 1'b1, 1'b1);
    send_item(asc_tb_pkg::OP_DEC, rand64(), rand64(), 5'd31, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_DEC, rand64(), rand64(), 5'd3, 1'b1, 1'b1);
    send_item(asc_tb_pkg::OP_INIT, rand64(), rand64(), 5'd0, 1'b1, 1'b1);
    send_item(asc_tb_pkg::OP_AD, rand64(), rand64(), 5'd9, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_ENC, rand64(), rand64(), 5'd0, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_DEC, rand64(), rand64(), 5'd16, 1'b0, 1'b1);
    send_item(asc_tb_pkg::OP_FIN, rand64(), rand64(), 5'd8, 1'b1, 1'b1);
    send_item(asc_tb_pkg::OP_RSV5, rand64(), rand64(), 5'd16, 1'b1, 1'b0);
    send_item(asc_tb_pkg::OP_RSV6, rand64(), rand64(), 5'd7, 1'b0, 1'b0);
    send_item(asc_tb_pkg::OP_RSV7, rand64(), rand64(), 5'd31, 1'b1, 1'b0);
  endtask

  task automatic random_items(int target);
    int  goal, half, n_ad, n_txt, i;
    bit  keyed, ad_close, txt_close, held;
    logic lb;
    asc_tb_pkg::op_e op, dir;
    goal = items_sent + target;
    half = items_sent + target / 2;
    held = 1'b0;
    while (items_sent < goal) begin
      if ($urandom_range(99) == 0 || (!held && items_sent >= half)) begin
        hold_off();
        held = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        // stray item outside any sequence
        op = asc_tb_pkg::op_e'($urandom_range(7));
        send_item(op, rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom_range(1)),
                  op == asc_tb_pkg::OP_INIT || op == asc_tb_pkg::OP_FIN);
      end else begin
        keyed = ($urandom_range(19) != 0);
        if (keyed)
          send_item(asc_tb_pkg::OP_INIT, rand64(), rand64(), 5'($urandom_range(31)),
                    1'($urandom_range(1)), 1'b1);
        n_ad     = $urandom_range(3);
        ad_close = 1'($urandom_range(1));
        if (n_ad == 0 && ad_close)
          send_item(asc_tb_pkg::OP_AD, rand64(), rand64(), 5'd0, 1'b1, keyed);
        for (i = 0; i < n_ad; i++) begin
          lb = (i == n_ad - 1) && ad_close;
          send_item(asc_tb_pkg::OP_AD, rand64(), rand64(), lb ? tail_count() : body_count(),
                    lb, keyed);
        end
        n_txt     = $urandom_range(4);
        txt_close = ($urandom_range(3) != 0);
        dir       = $urandom_range(1) ? asc_tb_pkg::OP_DEC : asc_tb_pkg::OP_ENC;
        for (i = 0; i < n_txt; i++) begin
          lb = (i == n_txt - 1) && txt_close;
          op = ($urandom_range(7) == 0) ?
               ((dir == asc_tb_pkg::OP_ENC) ? asc_tb_pkg::OP_DEC : asc_tb_pkg::OP_ENC) : dir;
          send_item(op, rand64(), rand64(), lb ? tail_count() : body_count(), lb, keyed);
        end
        if ($urandom_range(9) != 0)
          send_item(asc_tb_pkg::OP_FIN, rand64(), rand64(), 5'($urandom_range(31)),
                    1'($urandom_range(1)), 1'b1);
      end
    end
  endtask

  task automatic run_phase(int s_idle, int r_stall, logic [63:0] kh, logic [63:0] kl);
    write_key(kh, kl);
    idle_pct = s_idle;
    stall_pct <= r_stall;
    random_items(PHASE_ITEMS);
    settle();
  endtask

  initial begin : stim
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_key(ONES64, ZERO64);
    directed_items();
    settle();
    run_phase(0, 0, ZERO64, ONES64);
    run_phase(56, 0, rand64(), rand64());
    run_phase(0, 56, ZERO64, ZERO64);
    run_phase(10, 10, ONES64, rand64());
    $display("covered %0d input items under five key settings and four idle/stall mixes",
             items_sent);
    $display("compared %0d text blocks and %0d tags", text_seen, tag_seen);
    if (fail_count == 0 && expected_left == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
src/asc_pkg.sv
src/asc_datapath.sv
src/asc_ctrl.sv
src/aead_sponge_cipher_core.sv
tb/sv/aead_sponge_cipher_checker.sv
tb/sv/tb_aead_sponge_cipher_core.sv
